@@ src/lqla_pkg.sv @@
// ----------------------------------------------------------------------------
// lqla_pkg
// Shared types and constants of the longest-queue lane arbiter: payload
// structs, opcodes, register indexes, controller states and command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lqla_pkg;

    // Default sizing of the lane store
    localparam int DEF_MAX_LANES  = 16;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed field widths
    localparam int LANE_FIELD_W = 4;
    localparam int NLANES_W     = 5;
    localparam int THRESH_W     = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Operation codes
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_GRANT   = 1'b1;

    // Register index (paddr[2])
    localparam logic REG_NUM_LANES = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    // Reset values of the registers
    localparam logic [NLANES_W-1:0] NUM_LANES_RST = 5'd16;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 16'hFFFF;

    typedef struct packed {
        logic                    op;
        logic [LANE_FIELD_W-1:0] lane;
    } lqla_in_t;

    typedef struct packed {
        logic [LANE_FIELD_W-1:0] result_lane;
        logic                    moved;
        logic                    congested;
        logic                    grant_valid;
    } lqla_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DEST_RD,
        ST_WRITE
    } lqla_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted item
        logic scan_rd;  // read the next lane in the scan
        logic dest_rd;  // read the destination lane
        logic wr;       // update the destination lane and load the result
    } lqla_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;  // grant, or congested arrival
        logic scan_last;  // the lane about to be read is the last in use
        logic out_free;   // result register can take a new result
    } lqla_sts_t;

endpackage

`default_nettype wire

@@ src/lqla_ctrl.sv @@
// ----------------------------------------------------------------------------
// lqla_ctrl
// Sequencer of the arbiter: accepts one item, steps the lane scan, reads and
// updates the destination lane, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lqla_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lqla_pkg::lqla_sts_t sts,
    output lqla_pkg::lqla_cmd_t      cmd
);
    import lqla_pkg::*;

    lqla_state_t state_reg;
    lqla_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!sts.need_scan) begin
                    state_next = ST_WRITE;
                end else if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DEST_RD;
            end
            ST_DEST_RD: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                // without a scan the destination is the arrival's own lane
                cmd.scan_rd = sts.need_scan;
                cmd.dest_rd = !sts.need_scan;
            end
            ST_DRAIN: begin
                cmd = '0;
            end
            ST_DEST_RD: begin
                cmd.dest_rd = 1'b1;
            end
            ST_WRITE: begin
                cmd.wr = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/lqla_datapath.sv @@
// ----------------------------------------------------------------------------
// lqla_datapath
// Lane counters in two memories, total arrival counter, scan comparator with
// best-lane tracking, destination update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lqla_datapath #(
    parameter int MAX_LANES  = lqla_pkg::DEF_MAX_LANES,
    parameter int COUNT_BITS = lqla_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [lqla_pkg::NLANES_W-1:0]       num_lanes,
    input  wire logic [lqla_pkg::THRESH_W-1:0]       threshold,
    input  wire lqla_pkg::lqla_in_t                  s_data,
    output lqla_pkg::lqla_out_t                      m_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    input  wire lqla_pkg::lqla_cmd_t                 cmd,
    output lqla_pkg::lqla_sts_t                      sts
);
    import lqla_pkg::*;

    localparam int LANE_W = $clog2(MAX_LANES);
    localparam int CW     = COUNT_BITS;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    // Lane counter memories
    logic [CW-1:0] tally_mem [MAX_LANES];
    logic [CW-1:0] wait_mem  [MAX_LANES];
    logic [MAX_LANES-1:0] tally_vld_reg;
    logic [MAX_LANES-1:0] wait_vld_reg;

    logic              op_reg;
    logic [LANE_W-1:0] lane_reg;
    logic              cong_reg;
    logic [CW-1:0]     total_reg;
    logic [LANE_W-1:0] issue_idx_reg;
    logic              cmp_vld_reg;
    logic [LANE_W-1:0] cmp_idx_reg;
    logic [CW-1:0]     best_val_reg;
    logic [LANE_W-1:0] best_idx_reg;
    logic              have_reg;
    logic [CW-1:0]     rd_tally_raw_reg;
    logic [CW-1:0]     rd_wait_raw_reg;
    logic              rd_tv_reg;
    logic              rd_wv_reg;
    lqla_out_t         out_reg;
    logic              m_valid_reg;

    logic [LANE_W-1:0] n_m1;
    logic [LANE_W-1:0] lane_in;
    logic [CW-1:0]     total_next;
    logic              cong_next;
    logic [LANE_W-1:0] dest;
    logic              rd_en;
    logic [LANE_W-1:0] rd_addr;
    logic [CW-1:0]     rd_tally;
    logic [CW-1:0]     rd_wait;
    logic [CW-1:0]     cand;
    logic              take;
    logic              is_arrival;
    logic              wr_tally;
    logic              wr_wait;
    logic [CW-1:0]     tally_new;
    logic [CW-1:0]     wait_new;
    lqla_out_t         out_next;

    // Last lane in use: zero lanes act as one, too many act as the maximum
    always_comb begin
        if (num_lanes == '0) begin
            n_m1 = '0;
        end else if (32'(num_lanes) > 32'(MAX_LANES)) begin
            n_m1 = LANE_W'(MAX_LANES - 1);
        end else begin
            n_m1 = LANE_W'(num_lanes - NLANES_W'(1));
        end
    end

    // Saturate the arrival lane to the last lane in use
    assign lane_in    = (32'(s_data.lane) > 32'(n_m1)) ? n_m1 : LANE_W'(s_data.lane);
    assign total_next = sat_inc(total_reg);
    assign cong_next  = 32'(total_next) > 32'(threshold);

    assign is_arrival = (op_reg == OP_ARRIVAL);
    assign dest       = (is_arrival && !cong_reg) ? lane_reg : best_idx_reg;

    // Latch the item and restart the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.load && (s_data.op == OP_ARRIVAL)) begin
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_data.op;
            lane_reg <= lane_in;
            cong_reg <= (s_data.op == OP_ARRIVAL) && cong_next;
        end
    end

    // Advance the scan address and tag the read in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            issue_idx_reg <= '0;
        end else if (cmd.scan_rd) begin
            issue_idx_reg <= issue_idx_reg + LANE_W'(1);
        end
        if (cmd.scan_rd) begin
            cmp_idx_reg <= issue_idx_reg;
        end
    end

    // Memory read port, data registered
    assign rd_en   = cmd.scan_rd || cmd.dest_rd;
    assign rd_addr = cmd.scan_rd ? issue_idx_reg : dest;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_tally_raw_reg <= tally_mem[rd_addr];
            rd_wait_raw_reg  <= wait_mem[rd_addr];
            rd_tv_reg        <= tally_vld_reg[rd_addr];
            rd_wv_reg        <= wait_vld_reg[rd_addr];
        end
    end

    // Entries never written read as zero
    assign rd_tally = rd_tv_reg ? rd_tally_raw_reg : '0;
    assign rd_wait  = rd_wv_reg ? rd_wait_raw_reg  : '0;

    // Compare: arrivals see their own lane already raised by one
    always_comb begin
        if (is_arrival) begin
            cand = (cmp_idx_reg == lane_reg) ? sat_inc(rd_tally) : rd_tally;
            take = !have_reg || (cand > best_val_reg);
        end else begin
            cand = rd_wait;
            take = cand > best_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            best_val_reg <= '0;
            best_idx_reg <= '0;
            have_reg     <= 1'b0;
        end else if (cmp_vld_reg && take) begin
            best_val_reg <= cand;
            best_idx_reg <= cmp_idx_reg;
            have_reg     <= 1'b1;
        end
    end

    // Destination update
    assign wr_tally  = cmd.wr && is_arrival;
    assign wr_wait   = cmd.wr && (is_arrival || have_reg);
    assign tally_new = sat_inc(rd_tally);
    assign wait_new  = is_arrival ? sat_inc(rd_wait) : rd_wait - CW'(1);

    always_ff @(posedge aclk) begin
        if (wr_tally) begin
            tally_mem[dest] <= tally_new;
        end
        if (wr_wait) begin
            wait_mem[dest] <= wait_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_vld_reg <= '0;
            wait_vld_reg  <= '0;
        end else begin
            if (wr_tally) begin
                tally_vld_reg[dest] <= 1'b1;
            end
            if (wr_wait) begin
                wait_vld_reg[dest] <= 1'b1;
            end
        end
    end

    // Result fields
    always_comb begin
        out_next.result_lane = (!is_arrival && !have_reg) ? '0 : LANE_FIELD_W'(dest);
        out_next.moved       = is_arrival && (dest != lane_reg);
        out_next.congested   = is_arrival && cong_reg;
        out_next.grant_valid = !is_arrival && have_reg;
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.wr) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign sts.need_scan = !is_arrival || cong_reg;
    assign sts.scan_last = (issue_idx_reg == n_m1);
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

@@ src/longest_queue_lane_arbiter.sv @@
// An arrival below the congestion threshold goes to its own lane without a scan;
// a grant or a congested arrival scans the n lanes in use first (one lane counter
// read per cycle over a single memory port). The block takes one item at a time;
// a waiting result does not block acceptance of the next item. Reset (synchronous,
// aresetn low) clears all lane counters, the total count and the registers to
// their reset values.
// ----------------------------------------------------------------------------
// longest_queue_lane_arbiter
// Lane arbiter with per-lane arrival tallies and waiting counts: congested
// arrivals join the busiest lane, grants go to the longest queue.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_queue_lane_arbiter #(
    parameter int MAX_LANES  = lqla_pkg::DEF_MAX_LANES,
    parameter int COUNT_BITS = lqla_pkg::DEF_COUNT_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire lqla_pkg::lqla_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output lqla_pkg::lqla_out_t                    m_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lqla_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lqla_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lqla_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import lqla_pkg::*;

    logic [NLANES_W-1:0] num_lanes_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic                reg_idx;
    logic                cfg_wr;
    lqla_cmd_t           cmd;
    lqla_sts_t           sts;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_lanes_reg <= NUM_LANES_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NUM_LANES: num_lanes_reg <= pwdata[NLANES_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_W-1:0];
                default:       num_lanes_reg <= num_lanes_reg;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_NUM_LANES: prdata = APB_DATA_W'(num_lanes_reg);
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    lqla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lqla_datapath #(
        .MAX_LANES  (MAX_LANES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .num_lanes (num_lanes_reg),
        .threshold (threshold_reg),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // One item at a time: after a transfer in, the block is busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // The update step only fires into a free result register
    a_wr_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> sts.out_free)
        else $error("result overwritten before transfer");

    // A new result appears only from an update step
    a_result_from_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.wr))
        else $error("result raised without an update step");

endmodule

`default_nettype wire

@@ verif/lqla_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lqla_checker
// Watches the arrival/grant channel, the result channel and the register
// port of the lane arbiter. Keeps its own lane tallies, waiting counts and
// arrival total, predicts the result of every accepted item and compares
// each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lqla_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  lqla_pkg::lqla_in_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  lqla_pkg::lqla_out_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [lqla_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lqla_pkg::APB_DATA_W-1:0] pwdata,
    output int                              errors,
    output int                              pending
);
    import lqla_pkg::*;

    localparam int LANES = DEF_MAX_LANES;
    localparam int CNT_W = DEF_COUNT_BITS;

    // Shadow copy of the registers and the lane store
    logic [NLANES_W-1:0] lanes_cfg;
    logic [THRESH_W-1:0] thresh_cfg;
    logic [CNT_W-1:0]    joined_cnt [LANES];
    logic [CNT_W-1:0]    queue_len  [LANES];
    logic [CNT_W-1:0]    arrivals_seen;

    lqla_out_t predicted_q [$];
    lqla_out_t want;

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the shadow store by one item and return the result it gives
    function automatic lqla_out_t arbitrate(lqla_in_t item);
        int unsigned     n;
        int unsigned     ln;
        int unsigned     dest;
        logic [CNT_W-1:0] v;
        logic [CNT_W-1:0] best;
        logic            hot;
        logic            have;
        lqla_out_t       r;
        r = '0;
        if (lanes_cfg == 0) n = 1;
        else if (lanes_cfg > LANES) n = LANES;
        else n = lanes_cfg;
        if (item.op == OP_ARRIVAL) begin
            ln = item.lane;
            if (ln >= n) ln = n - 1;
            arrivals_seen = bump(arrivals_seen);
            hot  = arrivals_seen > thresh_cfg;
            dest = ln;
            // Congested: join the busiest lane, own lane counted one higher
            if (hot) begin
                have = 1'b0;
                best = '0;
                for (int unsigned i = 0; i < n; i++) begin
                    v = (i == ln) ? bump(joined_cnt[i]) : joined_cnt[i];
                    if (!have || v > best) begin
                        best = v;
                        dest = i;
                        have = 1'b1;
                    end
                end
            end
            joined_cnt[dest] = bump(joined_cnt[dest]);
            queue_len[dest]  = bump(queue_len[dest]);
            r.result_lane = 4'(dest);
            r.moved       = (dest != ln);
            r.congested   = hot;
        end else begin
            // Grant the longest queue, lowest index on ties
            best = '0;
            have = 1'b0;
            dest = 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (queue_len[i] > best) begin
                    best = queue_len[i];
                    dest = i;
                    have = 1'b1;
                end
            end
            if (have) queue_len[dest] = queue_len[dest] - 1'b1;
            r.result_lane = have ? 4'(dest) : 4'd0;
            r.grant_valid = have;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lanes_cfg     = NUM_LANES_RST;
            thresh_cfg    = THRESHOLD_RST;
            arrivals_seen = '0;
            for (int i = 0; i < LANES; i++) begin
                joined_cnt[i] = '0;
                queue_len[i]  = '0;
            end
            predicted_q.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_NUM_LANES) lanes_cfg = pwdata[NLANES_W-1:0];
                else thresh_cfg = pwdata[THRESH_W-1:0];
            end
            // Compare a returned result with the oldest prediction
            if (m_valid && m_ready) begin
                if (predicted_q.size() == 0) begin
                    $error("result transfer with no prediction waiting: %p", m_data);
                    errors++;
                end else begin
                    want = predicted_q.pop_front();
                    if (m_data.result_lane !== want.result_lane) begin
                        $error("result_lane: expected %0d, actual %0d",
                               want.result_lane, m_data.result_lane);
                        errors++;
                    end
                    if (m_data.moved !== want.moved) begin
                        $error("moved: expected %0d, actual %0d", want.moved, m_data.moved);
                        errors++;
                    end
                    if (m_data.congested !== want.congested) begin
                        $error("congested: expected %0d, actual %0d",
                               want.congested, m_data.congested);
                        errors++;
                    end
                    if (m_data.grant_valid !== want.grant_valid) begin
                        $error("grant_valid: expected %0d, actual %0d",
                               want.grant_valid, m_data.grant_valid);
                        errors++;
                    end
                end
            end
            // Predict the result of an accepted item
            if (s_valid && s_ready) predicted_q.push_back(arbitrate(s_data));
        end
        pending = predicted_q.size();
    end

endmodule

@@ verif/tb_longest_queue_lane_arbiter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_longest_queue_lane_arbiter
// Drives arrivals and grant requests into the lane arbiter under several
// lane counts and congestion thresholds, with random gaps on both channels
// and one long result stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_longest_queue_lane_arbiter;
    import lqla_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 210;
    localparam int LONG_STALL    = 160;
    localparam int STALL_AT      = 700;
    localparam int SETTLE_CYCLES = 25;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    lqla_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    lqla_out_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   errors;
    int   pending;
    int   arrivals_sent;
    int   results_taken;
    int   quiet_cycles;
    logic idle_on;

    longest_queue_lane_arbiter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lqla_checker u_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one item after a random gap; return at the falling edge after the transfer
    task automatic offer(input logic op, input logic [LANE_FIELD_W-1:0] lane);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data.op   <= op;
        s_data.lane <= lane;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_ARRIVAL) arrivals_sent++;
        @(negedge aclk);
    endtask

    // Register write: setup cycle, access cycle, then back to idle
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Drain all results, let the block go idle, then load a new setting
    task automatic reconfigure(input int lanes, input int thresh);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_NUM_LANES, {27'($urandom), 5'(lanes)});
        write_reg(REG_THRESHOLD, {16'($urandom), 16'(thresh)});
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            offer(($urandom_range(0, 99) < 55) ? OP_ARRIVAL : OP_GRANT,
                  LANE_FIELD_W'($urandom));
        end
    endtask

    // Result side: random hold-off per transfer, one long stall to back up the input
    initial begin : result_side
        int gap;
        m_ready = 1'b0;
        results_taken = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = idle_on ? $urandom_range(0, 11) : 0;
            if (results_taken == STALL_AT) gap = LONG_STALL;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_taken++;
            @(negedge aclk);
        end
    end

    // End the run when no transfer happens for too long
    initial quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b1;
        arrivals_sent = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: grant with every lane empty, extreme lanes, tie on grant
        offer(OP_GRANT, 4'd9);
        offer(OP_ARRIVAL, 4'd0);
        offer(OP_ARRIVAL, 4'd15);
        offer(OP_ARRIVAL, 4'd7);
        offer(OP_ARRIVAL, 4'd15);
        offer(OP_GRANT, 4'd0);
        offer(OP_GRANT, 4'd15);

        // Four lanes, congested from the next arrival; out-of-range lane folds to lane 3
        reconfigure(4, arrivals_sent);
        offer(OP_ARRIVAL, 4'd3);
        offer(OP_ARRIVAL, 4'd9);
        offer(OP_GRANT, 4'd2);
        offer(OP_GRANT, 4'd0);
        offer(OP_GRANT, 4'd0);

        // Zero lanes acts as one; above the maximum acts as the maximum
        reconfigure(0, 65535);
        offer(OP_ARRIVAL, 4'd15);
        offer(OP_GRANT, 4'd5);
        offer(OP_GRANT, 4'd5);
        reconfigure(31, 0);
        offer(OP_ARRIVAL, 4'd15);
        offer(OP_ARRIVAL, 4'd5);
        offer(OP_GRANT, 4'd0);
        offer(OP_GRANT, 4'd0);

        // Random phases over a spread of settings
        reconfigure(16, 65535);
        random_phase(PHASE_ITEMS);
        reconfigure(5, arrivals_sent + 100);
        random_phase(PHASE_ITEMS);
        reconfigure(1, 0);
        random_phase(PHASE_ITEMS);
        reconfigure(31, arrivals_sent + 60);
        random_phase(PHASE_ITEMS);
        reconfigure(2, 65535);
        random_phase(PHASE_ITEMS);
        reconfigure(9, 0);
        random_phase(PHASE_ITEMS);

        // Drain and give the verdict
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
